### hw/rtl/page_bitmap_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core_assert.svh
// assertion macros shared by the page bitmap allocator checkers
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PBA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// shared types and constants of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

	// default sizing
	localparam int NUM_PAGES_DEF = 65536;
	localparam int WORD_BITS_DEF = 64;

	// pages reachable through a 16-bit page index
	localparam int INDEX_SPAN = 65536;

	// counter and register widths
	localparam int CNT_W = 17;
	localparam int IDX_W = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CNT_W-1:0] PAGE_LIMIT_RST = 17'h10000;

	// register select (paddr bit 2)
	localparam logic REG_PAGE_LIMIT = 1'b0;
	localparam logic REG_USED_COUNT = 1'b1;

	// command codes
	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_FREE      = 3'd1;
	localparam logic [2:0] CMD_MARK_FREE = 3'd2;
	localparam logic [2:0] CMD_MARK_USED = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;

	// controller states
	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_RMW  = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

endpackage

### hw/rtl/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// single-clock map memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pba_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/pba_ffs.sv
// ----------------------------------------------------------------------------
// pba_ffs
// lowest set bit finder over one map word
// ----------------------------------------------------------------------------
module pba_ffs #(
	parameter int WIDTH = 64,
	parameter int BW    = 6
) (
	input  logic [WIDTH-1:0] vec,
	output logic             found,
	output logic [BW-1:0]    pos,
	output logic [WIDTH-1:0] onehot
);

	// priority over bits, lowest wins
	always_comb begin
		pos = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				pos = BW'(i);
			end
		end
	end

	assign found  = |vec;
	assign onehot = vec & (~vec + WIDTH'(1));

endmodule

### hw/rtl/page_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// first-fit physical page allocator over a used-bit map held in a memory
// ----------------------------------------------------------------------------
//
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------
// command   | start, busy (busy low)  | cmd, page_id
// result    | done strobe, one cycle  | ok, is_used, page_number, used_count
// registers | psel/penable/pready     | paddr, pwdata, prdata
//
// free, mark, query and unknown commands: one map read-modify-write
// allocate: k map words scanned one per cycle through the read port; k is at
// least 1 and at most ceil(effective limit / WORD_BITS), or 1 for a zero limit
// after reset a clearing pass writes ones into all ceil(NUM_PAGES / WORD_BITS)
// map words; busy stays high meanwhile
// results are strobed and cannot be held off by the receiver
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core #(
	parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF,
	parameter int WORD_BITS = pba_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command word
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  cmd,
	input  logic [pba_pkg::IDX_W-1:0]   page_id,
	// result word
	output logic                        done,
	output logic                        ok,
	output logic                        is_used,
	output logic [pba_pkg::IDX_W-1:0]   page_number,
	output logic [pba_pkg::CNT_W-1:0]   used_count,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pba_pkg::ADDR_W-1:0]  paddr,
	input  logic [pba_pkg::DATA_W-1:0]  pwdata,
	output logic [pba_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CAP       = (NUM_PAGES < pba_pkg::INDEX_SPAN) ? NUM_PAGES
	                           : pba_pkg::INDEX_SPAN;
	// reciprocal for index / WORD_BITS, exact over 16-bit indices
	localparam int SH        = pba_pkg::IDX_W + BW;
	localparam logic [17:0] RECIP = 18'(((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS);
	localparam int PROD_W    = pba_pkg::IDX_W + 18;

	localparam int CW = pba_pkg::CNT_W;

	pba_pkg::state_t state_q;

	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    cur_q;
	logic [CW-1:0]    base_q;
	logic [2:0]       cmd_q;
	logic             inr_q;
	logic [15:0]      idx_q;
	logic [15:0]      qidx_q;
	logic [CW-1:0]    page_limit_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic             ok_q;
	logic             is_used_q;
	logic [15:0]      page_q;

	logic             accept;
	logic             cfg_wr;
	logic [CW-1:0]    eff_lim;
	logic             in_range;
	logic [PROD_W-1:0] prod;
	logic [15:0]      q_comb;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [WORD_BITS-1:0] rd_data;

	logic [CW-1:0]    n_left;
	logic             scan_in_win;
	logic             scan_last;
	logic [WORD_BITS-1:0] win_mask;
	logic [WORD_BITS-1:0] free_vec;
	logic             found;
	logic [BW-1:0]    found_pos;
	logic [WORD_BITS-1:0] found_oh;
	logic             scan_end;

	logic [15:0]      diff;
	logic [BW-1:0]    rem;
	logic             cur_bit;
	logic [WORD_BITS-1:0] bit_oh;
	logic             free_hit;

	// handshakes
	assign accept = start && (state_q == pba_pkg::S_IDLE);
	assign busy   = (state_q != pba_pkg::S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// register reads
	assign prdata = (paddr[2] == pba_pkg::REG_USED_COUNT) ? {15'd0, cnt_q}
	                : {15'd0, page_limit_q};

	// effective page limit
	assign eff_lim  = (page_limit_q > CW'(CAP)) ? CW'(CAP) : page_limit_q;
	assign in_range = {1'b0, page_id} < eff_lim;

	// word address of the incoming index
	assign prod   = PROD_W'(page_id) * PROD_W'(RECIP);
	assign q_comb = 16'(prod >> SH);

	// bit position inside the word being modified
	assign diff    = idx_q - (qidx_q * 16'(WORD_BITS));
	assign rem     = diff[BW-1:0];
	assign cur_bit = rd_data[rem];
	assign bit_oh  = WORD_BITS'(1) << rem;
	assign free_hit = inr_q && cur_bit;

	// scan window of the current word
	assign scan_in_win = base_q < eff_lim;
	assign n_left      = eff_lim - base_q;
	assign scan_last   = (base_q + CW'(WORD_BITS)) >= eff_lim;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			win_mask[i] = scan_in_win && (CW'(i) < n_left);
		end
	end

	assign free_vec = ~rd_data & win_mask;
	assign scan_end = found || scan_last;

	pba_ffs #(
		.WIDTH (WORD_BITS),
		.BW    (BW)
	) u_ffs (
		.vec    (free_vec),
		.found  (found),
		.pos    (found_pos),
		.onehot (found_oh)
	);

	// map write port
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = rd_data;
		case (state_q)
			pba_pkg::S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '1;
			end
			pba_pkg::S_RMW: begin
				waddr = AW'(qidx_q);
				case (cmd_q)
					pba_pkg::CMD_FREE: begin
						we    = free_hit;
						wdata = rd_data & ~bit_oh;
					end
					pba_pkg::CMD_MARK_FREE: begin
						we    = inr_q;
						wdata = rd_data & ~bit_oh;
					end
					pba_pkg::CMD_MARK_USED: begin
						we    = inr_q;
						wdata = rd_data | bit_oh;
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			pba_pkg::S_SCAN: begin
				we    = found;
				waddr = cur_q;
				wdata = rd_data | found_oh;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// map read address
	always_comb begin
		case (state_q)
			pba_pkg::S_IDLE: begin
				raddr = (cmd == pba_pkg::CMD_ALLOC) ? '0 : AW'(q_comb);
			end
			pba_pkg::S_SCAN: begin
				raddr = cur_q + AW'(1);
			end
			default: begin
				raddr = cur_q;
			end
		endcase
	end

	pba_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pba_pkg::S_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				pba_pkg::S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= pba_pkg::S_IDLE;
					end
				end
				pba_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= (cmd == pba_pkg::CMD_ALLOC) ? pba_pkg::S_SCAN
						           : pba_pkg::S_RMW;
					end
				end
				pba_pkg::S_RMW: begin
					done_q  <= 1'b1;
					state_q <= pba_pkg::S_IDLE;
				end
				pba_pkg::S_SCAN: begin
					if (scan_end) begin
						done_q  <= 1'b1;
						state_q <= pba_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= pba_pkg::S_IDLE;
				end
			endcase
		end
	end

	// command context and scan position
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			inr_q  <= in_range;
			idx_q  <= page_id;
			qidx_q <= q_comb;
			cur_q  <= '0;
			base_q <= '0;
		end else if (state_q == pba_pkg::S_SCAN && !scan_end) begin
			cur_q  <= cur_q + AW'(1);
			base_q <= base_q + CW'(WORD_BITS);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == pba_pkg::S_RMW) begin
			page_q <= '0;
			case (cmd_q)
				pba_pkg::CMD_FREE: begin
					ok_q      <= free_hit;
					is_used_q <= 1'b0;
				end
				pba_pkg::CMD_MARK_FREE, pba_pkg::CMD_MARK_USED: begin
					ok_q      <= inr_q;
					is_used_q <= 1'b0;
				end
				pba_pkg::CMD_QUERY: begin
					ok_q      <= inr_q;
					is_used_q <= inr_q ? cur_bit : 1'b1;
				end
				default: begin
					ok_q      <= 1'b0;
					is_used_q <= 1'b0;
				end
			endcase
		end else if (state_q == pba_pkg::S_SCAN && scan_end) begin
			ok_q      <= found;
			is_used_q <= 1'b0;
			page_q    <= found ? 16'(base_q + CW'(found_pos)) : '0;
		end
	end

	// configuration registers and used page counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= pba_pkg::PAGE_LIMIT_RST;
			cnt_q        <= '0;
		end else begin
			if (cfg_wr && paddr[2] == pba_pkg::REG_PAGE_LIMIT) begin
				page_limit_q <= pwdata[CW-1:0];
			end
			if (cfg_wr && paddr[2] == pba_pkg::REG_USED_COUNT) begin
				cnt_q <= pwdata[CW-1:0];
			end else if (state_q == pba_pkg::S_RMW && cmd_q == pba_pkg::CMD_FREE
			             && free_hit && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (state_q == pba_pkg::S_SCAN && found
			             && cnt_q != pba_pkg::COUNT_MAX) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign is_used     = is_used_q;
	assign page_number = page_q;
	assign used_count  = cnt_q;

endmodule

### hw/rtl/pba_checker.sv
// ----------------------------------------------------------------------------
// pba_checker
// port-level checks of the page bitmap allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_core_assert.svh"

module pba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      ok,
	input logic [pba_pkg::IDX_W-1:0] page_number,
	input logic [pba_pkg::CNT_W-1:0] used_count
);

	// an accepted command keeps the block occupied in the cycle after it is taken
	`PBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

	// a result is shown only once the block is free again
	`PBA_ASSERT_NOW(a_done_idle, done, !busy, "result word while busy")

	// every result closes a busy period
	`PBA_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result word without prior work")

	// a page number is reported only for a successful allocation
	`PBA_ASSERT_NOW(a_fail_no_page, done && !ok, page_number == '0, "page number on failure")

	// a nonzero allocated page always leaves the counter nonzero
	`PBA_ASSERT_NOW(a_alloc_count, done && page_number != '0, ok && used_count != '0,
		"allocation with empty counter")

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (.*);

### tb/sv/pba_reply_checker.sv
// ----------------------------------------------------------------------------
// pba_reply_checker
// Watches the command, result and register channels of the page bitmap
// allocator. Keeps its own used-page map, counter and limit, works out the
// reply of every accepted command word and compares it with the strobed
// result word, field by field, in order.
// ----------------------------------------------------------------------------
module pba_reply_checker #(
	parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [2:0]                  cmd,
	input  logic [pba_pkg::IDX_W-1:0]   page_id,
	input  logic                        done,
	input  logic                        ok,
	input  logic                        is_used,
	input  logic [pba_pkg::IDX_W-1:0]   page_number,
	input  logic [pba_pkg::CNT_W-1:0]   used_count,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [pba_pkg::ADDR_W-1:0]  paddr,
	input  logic [pba_pkg::DATA_W-1:0]  pwdata,
	output int                          fail_count,
	output int                          pending_count,
	output int                          results_checked,
	output int                          grants,
	output int                          refusals
);

	localparam int IW = pba_pkg::IDX_W;
	localparam int CW = pba_pkg::CNT_W;

	// pages reachable by both the map and the index
	localparam int MAP_PAGES = (NUM_PAGES < pba_pkg::INDEX_SPAN) ? NUM_PAGES
	                           : pba_pkg::INDEX_SPAN;
	localparam int PRINT_CAP = 50;

	typedef struct packed {
		logic [2:0]    op;
		logic [IW-1:0] index;
		logic          ok;
		logic          is_used;
		logic [IW-1:0] page_number;
		logic [CW-1:0] used_count;
	} page_reply_t;

	// predicted block state
	bit            page_taken [MAP_PAGES];
	logic [CW-1:0] pages_in_use;
	logic [CW-1:0] limit_reg;

	page_reply_t expected_replies [$];
	page_reply_t due;

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: reply mismatch: %s", $time, msg);
	endtask

	// limit actually in force
	function automatic int unsigned active_limit();
		if (limit_reg > MAP_PAGES)
			return MAP_PAGES;
		return limit_reg;
	endfunction

	// apply one command word to the predicted state and build its reply
	function automatic page_reply_t predict_reply(logic [2:0] op, logic [IW-1:0] idx);
		page_reply_t r;
		int unsigned lim;
		int unsigned p;
		bit hit;
		r = '0;
		r.op = op;
		r.index = idx;
		lim = active_limit();
		hit = idx < lim;
		case (op)
			pba_pkg::CMD_ALLOC: begin
				for (p = 0; p < lim; p++) begin
					if (!page_taken[p])
						break;
				end
				if (p < lim) begin
					page_taken[p] = 1'b1;
					if (pages_in_use != pba_pkg::COUNT_MAX)
						pages_in_use = pages_in_use + 1'b1;
					r.ok = 1'b1;
					r.page_number = p[IW-1:0];
				end
			end
			pba_pkg::CMD_FREE: begin
				if (hit && page_taken[idx]) begin
					page_taken[idx] = 1'b0;
					if (pages_in_use != '0)
						pages_in_use = pages_in_use - 1'b1;
					r.ok = 1'b1;
				end
			end
			pba_pkg::CMD_MARK_FREE, pba_pkg::CMD_MARK_USED: begin
				if (hit) begin
					page_taken[idx] = (op == pba_pkg::CMD_MARK_USED);
					r.ok = 1'b1;
				end
			end
			pba_pkg::CMD_QUERY: begin
				r.ok = hit;
				r.is_used = hit ? page_taken[idx] : 1'b1;
			end
			default: ;
		endcase
		r.used_count = pages_in_use;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_PAGES; i++)
				page_taken[i] = 1'b1;
			pages_in_use = '0;
			limit_reg = pba_pkg::PAGE_LIMIT_RST;
			expected_replies.delete();
			fail_count = 0;
			pending_count = 0;
			results_checked = 0;
			grants = 0;
			refusals = 0;
		end else begin
			// result word against the oldest prediction
			if (done) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					due = expected_replies.pop_front();
					results_checked++;
					if (ok !== due.ok)
						report_mismatch($sformatf("op %0d idx %0h ok got %b want %b",
							due.op, due.index, ok, due.ok));
					if (is_used !== due.is_used)
						report_mismatch($sformatf("op %0d idx %0h is_used got %b want %b",
							due.op, due.index, is_used, due.is_used));
					if (page_number !== due.page_number)
						report_mismatch($sformatf("op %0d idx %0h page_number got %0h want %0h",
							due.op, due.index, page_number, due.page_number));
					if (used_count !== due.used_count)
						report_mismatch($sformatf("op %0d idx %0h used_count got %0h want %0h",
							due.op, due.index, used_count, due.used_count));
				end
			end
			// register write, paddr bit 2 selects the register
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == pba_pkg::REG_PAGE_LIMIT)
					limit_reg = pwdata[CW-1:0];
				else
					pages_in_use = pwdata[CW-1:0];
			end
			// accepted command word
			if (start && !busy) begin
				due = predict_reply(cmd, page_id);
				expected_replies.push_back(due);
				if (cmd == pba_pkg::CMD_ALLOC) begin
					if (due.ok)
						grants++;
					else
						refusals++;
				end
			end
			pending_count = expected_replies.size();
		end
	end

endmodule

### tb/sv/tb_page_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator_core
// Drives command words and register writes into the page bitmap allocator:
// a directed pass over boundaries, saturation and unknown commands, then
// random traffic over a series of page limits and counter loads with random
// gaps. The reply checker beside the block does the prediction and compare.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_core;

	localparam int IW = pba_pkg::IDX_W;
	localparam int CW = pba_pkg::CNT_W;
	localparam int DW = pba_pkg::DATA_W;
	localparam int RW = pba_pkg::ADDR_W;

	localparam int CLK_HALF = 4;
	localparam int CLK_PERIOD = 2 * CLK_HALF;
	localparam int RESET_CYCLES = 9;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	// longest allocate scan plus margin
	localparam int SETTLE_CYCLES = pba_pkg::NUM_PAGES_DEF / pba_pkg::WORD_BITS_DEF + 64;
	localparam int NUM_PHASES = 10;

	// command codes the block ignores
	localparam logic [2:0] CMD_SPARE_LO = pba_pkg::CMD_QUERY + 3'd1;
	localparam logic [2:0] CMD_SPARE_HI = 3'h7;

	// register byte addresses
	localparam logic [RW-1:0] ADDR_PAGE_LIMIT = {pba_pkg::REG_PAGE_LIMIT, 2'b00};
	localparam logic [RW-1:0] ADDR_USED_COUNT = {pba_pkg::REG_USED_COUNT, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         cmd = pba_pkg::CMD_ALLOC;
	logic [IW-1:0]      page_id = '0;
	logic               done;
	logic               ok;
	logic               is_used;
	logic [IW-1:0]      page_number;
	logic [CW-1:0]      used_count;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [RW-1:0]      paddr = '0;
	logic [DW-1:0]      pwdata = '0;
	logic [DW-1:0]      prdata;
	logic               pready;

	int fail_count;
	int pending_count;
	int results_checked;
	int grants;
	int refusals;

	int commands_sent = 0;
	int phases_run = 0;
	bit steady = 1'b0;

	logic [CW-1:0] phase_limit [NUM_PHASES] = '{
		17'd64, 17'd1, 17'd130, 17'd65, 17'd200,
		17'h10000, 17'd33, 17'd1000, 17'h1FFFF, 17'd128
	};
	int phase_items [NUM_PHASES] = '{50, 30, 50, 45, 50, 20, 40, 45, 15, 55};

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	page_bitmap_allocator_core #(
		.NUM_PAGES(pba_pkg::NUM_PAGES_DEF),
		.WORD_BITS(pba_pkg::WORD_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.page_id(page_id),
		.done(done),
		.ok(ok),
		.is_used(is_used),
		.page_number(page_number),
		.used_count(used_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pba_reply_checker #(
		.NUM_PAGES(pba_pkg::NUM_PAGES_DEF)
	) reply_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.page_id(page_id),
		.done(done),
		.ok(ok),
		.is_used(is_used),
		.page_number(page_number),
		.used_count(used_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.results_checked(results_checked),
		.grants(grants),
		.refusals(refusals)
	);

	// present one command word and hold it until the block takes it
	task automatic issue(logic [2:0] op, logic [IW-1:0] idx);
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		page_id <= idx;
		do @(posedge clk); while (busy !== 1'b0);
		commands_sent++;
	endtask

	// drop start and wait until every reply is back and the block is idle
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	// setup and access cycle of one register write
	task automatic write_reg(logic [RW-1:0] addr, logic [CW-1:0] value);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// idle gap between words, mostly short, noise on the payload
	task automatic pause();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= 3'($urandom);
			page_id <= IW'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic logic [2:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return pba_pkg::CMD_ALLOC;
		if (r < 50) return pba_pkg::CMD_FREE;
		if (r < 63) return pba_pkg::CMD_MARK_FREE;
		if (r < 73) return pba_pkg::CMD_MARK_USED;
		if (r < 95) return pba_pkg::CMD_QUERY;
		return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
	endfunction

	// mostly in range, some at the boundary, some anywhere
	function automatic logic [IW-1:0] pick_index(int unsigned lim);
		int unsigned span;
		int r;
		span = (lim > pba_pkg::INDEX_SPAN) ? pba_pkg::INDEX_SPAN : lim;
		r = $urandom_range(0, 9);
		if (span == 0 || r == 0)
			return IW'($urandom);
		if (r == 1)
			return IW'(span - 1 + $urandom_range(0, 1));
		return IW'($urandom_range(0, span - 1));
	endfunction

	function automatic logic [CW-1:0] pick_load();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 17'h10000;
			2: return pba_pkg::COUNT_MAX - CW'($urandom_range(0, 3));
			default: return CW'($urandom_range(0, 500));
		endcase
	endfunction

	// time limit
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("run stalled: time limit reached with %0d replies outstanding",
			pending_count);
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus and verdict
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset map is all used: full scan refusal, then edges of the index
		issue(pba_pkg::CMD_ALLOC, 16'hFFFF);
		issue(pba_pkg::CMD_QUERY, 16'h0000);
		issue(pba_pkg::CMD_QUERY, 16'hFFFF);
		// free with the counter at zero, then free of a free page
		issue(pba_pkg::CMD_FREE, 16'h0000);
		issue(pba_pkg::CMD_FREE, 16'h0000);
		issue(pba_pkg::CMD_MARK_FREE, 16'hFFFF);
		issue(pba_pkg::CMD_QUERY, 16'hFFFF);
		issue(pba_pkg::CMD_ALLOC, 16'h0000);
		issue(pba_pkg::CMD_ALLOC, 16'h5555);
		issue(pba_pkg::CMD_MARK_USED, 16'h1234);
		for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
			issue(3'(c), 16'hAAAA);

		// small limit with the counter at its top
		write_reg(ADDR_PAGE_LIMIT, 17'd100);
		write_reg(ADDR_USED_COUNT, pba_pkg::COUNT_MAX);
		issue(pba_pkg::CMD_FREE, 16'd99);
		issue(pba_pkg::CMD_QUERY, 16'd100);
		issue(pba_pkg::CMD_FREE, 16'd100);
		issue(pba_pkg::CMD_MARK_FREE, 16'd100);
		issue(pba_pkg::CMD_MARK_USED, 16'd100);
		issue(pba_pkg::CMD_ALLOC, 16'h0000);
		issue(pba_pkg::CMD_MARK_FREE, 16'd5);
		issue(pba_pkg::CMD_ALLOC, 16'h0000);
		issue(pba_pkg::CMD_ALLOC, 16'h0000);

		// zero limit: everything out of range
		write_reg(ADDR_PAGE_LIMIT, '0);
		issue(pba_pkg::CMD_QUERY, 16'h0000);
		issue(pba_pkg::CMD_ALLOC, 16'h0000);
		issue(pba_pkg::CMD_FREE, 16'h0000);
		write_reg(ADDR_USED_COUNT, '0);

		// random traffic, one limit per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_reg(ADDR_PAGE_LIMIT, phase_limit[ph]);
			write_reg(ADDR_USED_COUNT, pick_load());
			phases_run++;
			steady = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < phase_items[ph]; k++) begin
				pause();
				if ($urandom_range(0, 39) == 0)
					settle();
				issue(pick_cmd(), pick_index(phase_limit[ph]));
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d command words over %0d random limit phases, %0d replies compared",
			commands_sent, phases_run, results_checked);
		$display("allocations granted %0d, refused %0d", grants, refusals);
		if (fail_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/pba_ffs.sv
hw/rtl/page_bitmap_allocator_core.sv
hw/rtl/pba_checker.sv
tb/sv/pba_reply_checker.sv
tb/sv/tb_page_bitmap_allocator_core.sv
